// ===== rtl/core/decay_tail_tilt_chain_defines.svh =====
// assertion macros shared by the decay tail / tilt chain rtl
// expects signals named clock and reset in the including module
`ifndef DECAY_TAIL_TILT_CHAIN_DEFINES_SVH
`define DECAY_TAIL_TILT_CHAIN_DEFINES_SVH

// same-cycle implication
`define DTT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/dtt_pkg.sv =====
// shared constants for the decay tail / tilt chain
// no dependencies
`default_nettype none

package dtt_pkg;

   // default sizing
   localparam int unsigned DELAY_DEPTH_DEF = 131072;
   localparam int unsigned SAMPLE_BITS_DEF = 24;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 18;
   localparam int unsigned COEF_W     = 16;
   localparam int unsigned CFG_LEN_W  = 18;

   localparam logic [CSR_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY_LENGTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DAMPING_COEFF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TILT_AMOUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TILT_COEFF    = 3'd4;

   // register reset values
   localparam logic [COEF_W-1:0]    FEEDBACK_GAIN_RST = 16'd32768;
   localparam logic [CFG_LEN_W-1:0] DELAY_LENGTH_RST  = 18'd88200;
   localparam logic [COEF_W-1:0]    DAMPING_COEFF_RST = 16'd16253;
   localparam logic [COEF_W-1:0]    TILT_AMOUNT_RST   = 16'd0;
   localparam logic [COEF_W-1:0]    TILT_COEFF_RST    = 16'd7060;

   // gate decay 0.9999 as q0.24
   localparam int unsigned          GATE_SHIFT = 24;
   localparam logic [GATE_SHIFT-1:0] GATE_DECAY = 24'd16775539;

   // tilt gains, q1.15; the 0.7 cut factor is q0.16
   localparam int unsigned      TILT_MAG_W = COEF_W + 1;
   localparam int unsigned      GAIN_W     = 18;
   localparam logic [COEF_W-1:0] CUT_07    = 16'd45875;
   localparam logic [GAIN_W-1:0] UNITY_GAIN = 18'd32768;
   localparam int unsigned      GAIN_SHIFT = 15;
   localparam int unsigned      COEF_SHIFT = 16;

endpackage

`default_nettype wire

// ===== rtl/core/decay_tail_tilt_chain.sv =====
// Decay tail followed by a tilt equalizer: one signed q1.(SAMPLE_BITS-1) sample
// in, one processed sample out per request. The decay stage is a damped
// feedback delay line (soft clip, feedback gain, one-pole lowpass) ducked by a
// level gate; the tilt stage splits low and high bands with a one-pole
// crossover and weights them oppositely by tilt_amount. All arithmetic runs on
// one shared signed multiplier stepped by a small sequencer. A request is taken
// only when the sequencer is idle and the memory clear has finished; a request
// passes through 17 sequencer steps, at most one multiply per step, and the last
// step holds while the previous response is unclaimed. When delay_length has
// been lowered so that the write position lies at or beyond it, that request
// first folds the position into the length in a bit-serial remainder unit.
// After reset the delay memory is cleared one entry per cycle, with req_tready
// held low; csr writes are taken throughout. The finished sample sits in an
// output register, so the next request may be accepted before it is taken.
// depends on dtt_pkg, dtt_delay_ram and decay_tail_tilt_chain_defines.svh
`default_nettype none
`include "decay_tail_tilt_chain_defines.svh"

module decay_tail_tilt_chain #(
   parameter int unsigned DELAY_DEPTH = dtt_pkg::DELAY_DEPTH_DEF,
   parameter int unsigned SAMPLE_BITS = dtt_pkg::SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,

   // request channel
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // sample_in

   // response channel
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,  // sample_out

   // configuration writes
   input  logic                                csr_wr_en,
   input  logic [dtt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dtt_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // ---------------------------------------------------------------------
   // sizing
   // ---------------------------------------------------------------------
   localparam int unsigned SB      = SAMPLE_BITS;
   localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int unsigned AW      = $clog2(DELAY_DEPTH);
   localparam int unsigned LEN_W   = $clog2(DELAY_DEPTH + 1);
   localparam int unsigned CMP_W   = (dtt_pkg::CFG_LEN_W > LEN_W) ? dtt_pkg::CFG_LEN_W : LEN_W;
   localparam int unsigned CNT_W   = $clog2(AW);
   // multiplier operands a and b, sized for samples, filter states and constants
   localparam int unsigned MA      = SB + 3;
   localparam int unsigned MB      = (SB + 1 > dtt_pkg::GATE_SHIFT + 1) ?
                                     SB + 1 : dtt_pkg::GATE_SHIFT + 1;
   localparam int unsigned PW      = MA + MB;
   localparam int unsigned PW1     = PW + 1;
   // filter states may sit just past full scale
   localparam int unsigned LW      = SB + 2;
   localparam int unsigned CW      = dtt_pkg::COEF_W;
   localparam int unsigned GW      = dtt_pkg::GAIN_W;
   localparam int unsigned TMW     = dtt_pkg::TILT_MAG_W;

   localparam logic signed [MA-1:0] ONE_A = {3'b000, 1'b1, {(SB - 1){1'b0}}};
   localparam logic [SB-1:0]        ONE_G = {1'b1, {(SB - 1){1'b0}}};
   // loud threshold, 0.001 of full scale
   localparam logic [SB-1:0]        THRESH = SB'((64'd1 << (SB - 1)) / 64'd1000);
   localparam logic signed [PW:0]   SAT_HI = {{(PW + 2 - SB){1'b0}}, {(SB - 1){1'b1}}};
   localparam logic signed [PW:0]   SAT_LO = {{(PW + 2 - SB){1'b1}}, {(SB - 1){1'b0}}};

   // sequencer steps
   localparam logic [4:0] ST_IDLE = 5'd0;   // wait for a request
   localparam logic [4:0] ST_MOD  = 5'd1;   // fold write position into shortened length
   localparam logic [4:0] ST_READ = 5'd2;   // read tap, gate decay multiply
   localparam logic [4:0] ST_SQ   = 5'd3;   // gate update, r*r
   localparam logic [4:0] ST_U    = 5'd4;   // u = 1 - r^2, tilt cut multiply
   localparam logic [4:0] ST_RU   = 5'd5;   // tilt gains, r*u
   localparam logic [4:0] ST_C    = 5'd6;   // soft clip result
   localparam logic [4:0] ST_F    = 5'd7;   // c * feedback_gain
   localparam logic [4:0] ST_FD   = 5'd8;   // f - damping_lp
   localparam logic [4:0] ST_LPM  = 5'd9;   // damping multiply
   localparam logic [4:0] ST_LP   = 5'd10;  // damping_lp update
   localparam logic [4:0] ST_WR   = 5'd11;  // write back, lp * gate
   localparam logic [4:0] ST_D    = 5'd12;  // ducked decay output
   localparam logic [4:0] ST_XD   = 5'd13;  // d - crossover_lp
   localparam logic [4:0] ST_XM   = 5'd14;  // crossover multiply
   localparam logic [4:0] ST_X    = 5'd15;  // crossover_lp update
   localparam logic [4:0] ST_HP   = 5'd16;  // high band, low * low gain
   localparam logic [4:0] ST_HM   = 5'd17;  // high * high gain
   localparam logic [4:0] ST_OUT  = 5'd18;  // sum, saturate, hand to output register

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   logic [4:0]                 state_ff, state_in;

   // configuration
   logic [CW-1:0]              fb_gain_ff, fb_gain_in;
   logic [dtt_pkg::CFG_LEN_W-1:0] dly_len_ff, dly_len_in;
   logic [CW-1:0]              damp_coef_ff, damp_coef_in;
   logic signed [CW-1:0]       tilt_amt_ff, tilt_amt_in;
   logic [CW-1:0]              tilt_coef_ff, tilt_coef_in;

   // persistent filter state
   logic [AW-1:0]              wp_ff, wp_in;
   logic [SB-1:0]              gate_ff, gate_in;
   logic signed [LW-1:0]       lp_ff, lp_in;
   logic signed [LW-1:0]       xlp_ff, xlp_in;

   // per-request working registers
   logic signed [SB-1:0]       x_ff, x_in;
   logic                       loud_ff, loud_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [LEN_W-1:0]           rem_ff, rem_in;
   logic [AW-1:0]              div_ff, div_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [MA-1:0]       tmp_ff, tmp_in;
   logic signed [SB-1:0]       d_ff, d_in;
   logic signed [PW-1:0]       acc_ff, acc_in;
   logic signed [PW-1:0]       prod_ff, prod_in;
   logic [GW-1:0]              lg_ff, lg_in;
   logic [GW-1:0]              hg_ff, hg_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]       rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------------
   // combinational helpers
   // ---------------------------------------------------------------------
   logic signed [MA-1:0]       mul_a;
   logic signed [MB-1:0]       mul_b;
   logic                       mul_en;

   logic signed [SB-1:0]       x_req;
   logic [SB-1:0]              ax_req;
   logic                       loud_req;
   logic [CMP_W-1:0]           dl_cmp;
   logic [LEN_W-1:0]           len_req;
   logic                       need_mod;

   logic [LEN_W:0]             mod_trial;
   logic [LEN_W:0]             mod_len;
   logic [LEN_W:0]             mod_step;
   logic [LEN_W-1:0]           wp_plus;

   logic signed [PW-1:0]       sh_coef;
   logic signed [PW-1:0]       sh_sb;
   logic signed [PW-1:0]       sh_sb1;
   logic signed [PW-1:0]       sh_gate;
   logic signed [PW:0]         y_sum;

   logic signed [MA-1:0]       r_a;
   logic signed [MB-1:0]       r_b;
   logic                       t_neg;
   logic [TMW-1:0]             t_mag;
   logic [GW-1:0]              boost;
   logic [GW-1:0]              cut;

   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [SB-1:0]              ram_wr_data;
   logic [SB-1:0]              ram_rd_data;
   logic                       ram_busy;

   function automatic logic signed [SB-1:0] sat_sb(input logic signed [PW:0] v);
      logic signed [SB-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SB-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SB-1:0];
      end else begin
         r = v[SB-1:0];
      end
      return r;
   endfunction

   // request decode: loud test and active length clamp
   assign x_req    = $signed(req_tdata[SB-1:0]);
   assign ax_req   = x_req[SB-1] ? (~req_tdata[SB-1:0] + 1'b1) : req_tdata[SB-1:0];
   assign loud_req = (ax_req > THRESH);
   assign dl_cmp   = CMP_W'(dly_len_ff);

   always_comb begin
      if (dly_len_ff == '0) begin
         len_req = LEN_W'(1);
      end else if (dl_cmp > CMP_W'(DELAY_DEPTH)) begin
         len_req = LEN_W'(DELAY_DEPTH);
      end else begin
         len_req = LEN_W'(dly_len_ff);
      end
   end

   assign need_mod = (LEN_W'(wp_ff) >= len_req);

   // restoring remainder, one dividend bit per cycle, msb first
   assign mod_trial = {rem_ff, div_ff[AW-1]};
   assign mod_len   = {1'b0, len_ff};
   assign mod_step  = (mod_trial >= mod_len) ? (mod_trial - mod_len) : mod_trial;
   assign wp_plus   = LEN_W'(wp_ff) + 1'b1;

   // product scalings (arithmetic shifts, round toward minus infinity)
   assign sh_coef = prod_ff >>> dtt_pkg::COEF_SHIFT;
   assign sh_sb   = prod_ff >>> SB;
   assign sh_sb1  = prod_ff >>> (SB - 1);
   assign sh_gate = prod_ff >>> dtt_pkg::GATE_SHIFT;
   assign y_sum   = (PW1'(acc_ff) + PW1'(prod_ff)) >>> dtt_pkg::GAIN_SHIFT;

   // delayed sample as either multiplier operand
   assign r_a = MA'($signed(ram_rd_data));
   assign r_b = MB'($signed(ram_rd_data));

   // tilt magnitude and gain pieces
   assign t_neg = tilt_amt_ff[CW-1];
   assign t_mag = t_neg ? (TMW'(0) - {tilt_amt_ff[CW-1], tilt_amt_ff})
                        : {1'b0, tilt_amt_ff};
   assign boost = (GW'(t_mag) + (GW'(t_mag) << 1)) >> 1;
   assign cut   = sh_coef[GW-1:0];

   // ---------------------------------------------------------------------
   // sequencer and datapath next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      fb_gain_in   = fb_gain_ff;
      dly_len_in   = dly_len_ff;
      damp_coef_in = damp_coef_ff;
      tilt_amt_in  = tilt_amt_ff;
      tilt_coef_in = tilt_coef_ff;
      wp_in        = wp_ff;
      gate_in      = gate_ff;
      lp_in        = lp_ff;
      xlp_in       = xlp_ff;
      x_in         = x_ff;
      loud_in      = loud_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      tmp_in       = tmp_ff;
      d_in         = d_ff;
      acc_in       = acc_ff;
      lg_in        = lg_ff;
      hg_in        = hg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      mul_en       = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_data  = $unsigned(sat_sb(PW1'(x_ff) + PW1'(lp_ff)));

      // register writes, unknown indexes dropped
      if (csr_wr_en) begin
         case (csr_index)
            dtt_pkg::REG_FEEDBACK_GAIN: fb_gain_in   = csr_wdata[CW-1:0];
            dtt_pkg::REG_DELAY_LENGTH:  dly_len_in   = csr_wdata[dtt_pkg::CFG_LEN_W-1:0];
            dtt_pkg::REG_DAMPING_COEFF: damp_coef_in = csr_wdata[CW-1:0];
            dtt_pkg::REG_TILT_AMOUNT:   tilt_amt_in  = $signed(csr_wdata[CW-1:0]);
            dtt_pkg::REG_TILT_COEFF:    tilt_coef_in = csr_wdata[CW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               x_in    = x_req;
               loud_in = loud_req;
               len_in  = len_req;
               rem_in  = '0;
               div_in  = wp_ff;
               cnt_in  = CNT_W'(AW - 1);
               state_in = need_mod ? ST_MOD : ST_READ;
            end
         end
         ST_MOD: begin
            rem_in = mod_step[LEN_W-1:0];
            div_in = div_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               wp_in    = mod_step[AW-1:0];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            mul_en    = 1'b1;
            mul_a     = MA'(gate_ff);
            mul_b     = MB'(dtt_pkg::GATE_DECAY);
            state_in  = ST_SQ;
         end
         ST_SQ: begin
            gate_in  = loud_ff ? ONE_G : sh_gate[SB-1:0];
            mul_en   = 1'b1;
            mul_a    = r_a;
            mul_b    = r_b;
            state_in = ST_U;
         end
         ST_U: begin
            tmp_in   = ONE_A - $signed(sh_sb1[MA-1:0]);
            mul_en   = 1'b1;
            mul_a    = MA'(t_mag);
            mul_b    = MB'(dtt_pkg::CUT_07);
            state_in = ST_RU;
         end
         ST_RU: begin
            // cut side takes 0.7 of the tilt, boost side 1.5
            lg_in    = t_neg ? (dtt_pkg::UNITY_GAIN + boost) : (dtt_pkg::UNITY_GAIN - cut);
            hg_in    = t_neg ? (dtt_pkg::UNITY_GAIN - cut) : (dtt_pkg::UNITY_GAIN + boost);
            mul_en   = 1'b1;
            mul_a    = tmp_ff;
            mul_b    = r_b;
            state_in = ST_C;
         end
         ST_C: begin
            tmp_in   = r_a + $signed(sh_sb[MA-1:0]);
            state_in = ST_F;
         end
         ST_F: begin
            mul_en   = 1'b1;
            mul_a    = tmp_ff;
            mul_b    = MB'(fb_gain_ff);
            state_in = ST_FD;
         end
         ST_FD: begin
            tmp_in   = $signed(sh_coef[MA-1:0]) - MA'(lp_ff);
            state_in = ST_LPM;
         end
         ST_LPM: begin
            mul_en   = 1'b1;
            mul_a    = tmp_ff;
            mul_b    = MB'(damp_coef_ff);
            state_in = ST_LP;
         end
         ST_LP: begin
            lp_in    = lp_ff + $signed(sh_coef[LW-1:0]);
            state_in = ST_WR;
         end
         ST_WR: begin
            ram_wr_en = 1'b1;
            wp_in     = (wp_plus == len_ff) ? '0 : wp_plus[AW-1:0];
            mul_en    = 1'b1;
            mul_a     = MA'(lp_ff);
            mul_b     = MB'(gate_ff);
            state_in  = ST_D;
         end
         ST_D: begin
            d_in     = sat_sb(PW1'(x_ff) + PW1'(lp_ff) - PW1'(sh_sb));
            state_in = ST_XD;
         end
         ST_XD: begin
            tmp_in   = MA'(d_ff) - MA'(xlp_ff);
            state_in = ST_XM;
         end
         ST_XM: begin
            mul_en   = 1'b1;
            mul_a    = tmp_ff;
            mul_b    = MB'(tilt_coef_ff);
            state_in = ST_X;
         end
         ST_X: begin
            xlp_in   = xlp_ff + $signed(sh_coef[LW-1:0]);
            state_in = ST_HP;
         end
         ST_HP: begin
            tmp_in   = MA'(d_ff) - MA'(xlp_ff);
            mul_en   = 1'b1;
            mul_a    = MA'(xlp_ff);
            mul_b    = MB'(lg_ff);
            state_in = ST_HM;
         end
         ST_HM: begin
            acc_in   = prod_ff;
            mul_en   = 1'b1;
            mul_a    = tmp_ff;
            mul_b    = MB'(hg_ff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold here while the previous response is still unclaimed
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_sb(y_sum);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // shared multiplier, product held between uses
   assign prod_in = mul_en ? (mul_a * mul_b) : prod_ff;

   // ---------------------------------------------------------------------
   // register update
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fb_gain_ff   <= dtt_pkg::FEEDBACK_GAIN_RST;
         dly_len_ff   <= dtt_pkg::DELAY_LENGTH_RST;
         damp_coef_ff <= dtt_pkg::DAMPING_COEFF_RST;
         tilt_amt_ff  <= $signed(dtt_pkg::TILT_AMOUNT_RST);
         tilt_coef_ff <= dtt_pkg::TILT_COEFF_RST;
         wp_ff        <= '0;
         gate_ff      <= '0;
         lp_ff        <= '0;
         xlp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fb_gain_ff   <= fb_gain_in;
         dly_len_ff   <= dly_len_in;
         damp_coef_ff <= damp_coef_in;
         tilt_amt_ff  <= tilt_amt_in;
         tilt_coef_ff <= tilt_coef_in;
         wp_ff        <= wp_in;
         gate_ff      <= gate_in;
         lp_ff        <= lp_in;
         xlp_ff       <= xlp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      loud_ff     <= loud_in;
      len_ff      <= len_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      tmp_ff      <= tmp_in;
      d_ff        <= d_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      lg_ff       <= lg_in;
      hg_ff       <= hg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------------
   // delay memory
   // ---------------------------------------------------------------------
   dtt_delay_ram #(
      .DEPTH  (DELAY_DEPTH),
      .DATA_W (SAMPLE_BITS)
   ) u_delay_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (wp_ff),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data),
      .busy    (ram_busy)
   );

   // ---------------------------------------------------------------------
   // ports
   // ---------------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE) && !ram_busy;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'($unsigned(rsp_data_ff));

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `DTT_ASSERT_NOW(a_no_request_while_clearing, ram_busy, !req_tready, "request taken during memory clear")
   `DTT_ASSERT_NOW(a_tap_in_range, state_ff == ST_READ, LEN_W'(wp_ff) < len_ff, "write position beyond active length")
   `DTT_ASSERT_NEXT(a_rsp_only_from_out, (state_ff != ST_OUT) && !rsp_valid_ff, !rsp_valid_ff, "response raised outside final step")
   `DTT_ASSERT_NOW(a_gate_bounded, 1'b1, gate_ff <= ONE_G, "gate level above unity")
   `DTT_ASSERT_NEXT(a_len_held_in_flight, state_ff != ST_IDLE, $stable(len_ff), "active length changed mid request")

endmodule

`default_nettype wire

// ===== rtl/core/dtt_delay_ram.sv =====
// single-port delay line memory with a clearing sweep after reset
// depends on dtt_pkg for default sizing
`default_nettype none

module dtt_delay_ram #(
   parameter int unsigned DEPTH  = dtt_pkg::DELAY_DEPTH_DEF,
   parameter int unsigned DATA_W = dtt_pkg::SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wr_data,
   output logic [DATA_W-1:0]        rd_data,
   output logic                     busy
);

   localparam int unsigned AW = $clog2(DEPTH);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              busy_ff, busy_in;

   // one entry zeroed per cycle until the sweep reaches the top
   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem_ff[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

// ===== test/decay_tail_tilt_chain_test.sv =====
// self-checking testbench for decay_tail_tilt_chain: predicts every processed sample
// and checks each response in order against it, with random stalls on both channels
// depends on dtt_pkg and the decay_tail_tilt_chain rtl
`timescale 1ns / 100ps

module decay_tail_tilt_chain_test;
   import dtt_pkg::*;

   localparam int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF;
   localparam int unsigned DELAY_DEPTH = DELAY_DEPTH_DEF;
   localparam int unsigned DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;

   // q1.(SAMPLE_BITS-1) full scale and the gate threshold of 0.001
   localparam longint SAMPLE_ONE = longint'(1) << (SAMPLE_BITS - 1);
   localparam longint GATE_THRESH = SAMPLE_ONE / 1000;
   // 0.9999 as q0.24, 0.7 as q0.16, unity as q1.15
   localparam longint GATE_FALL_Q24 = 16775539;
   localparam longint CUT_SCALE = 45875;
   localparam longint UNITY_Q15 = 32768;

   // register indexes the block has no register for
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_ITEMS   = 237;
   localparam int unsigned TAIL_CYCLES   = 40;
   localparam int unsigned CYCLE_LIMIT   = 2000000;
   localparam int unsigned REPORT_CAP    = 40;

   // character of a run of random samples
   typedef enum int unsigned {
      TONE_FULL, TONE_MODERATE, TONE_QUIET, TONE_SILENT, TONE_EDGE
   } signal_mix_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;    // sample_in
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;        // sample_out

   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_FEEDBACK_GAIN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   decay_tail_tilt_chain DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state: the recirculating tail memory and the three filter / gate values
   logic signed [SAMPLE_BITS-1:0] tail_mem [DELAY_DEPTH];
   int unsigned tail_ptr = 0;
   longint gate_env = 0;
   longint tail_lp = 0;
   longint xover_lp = 0;

   // predictor copy of the registers, starting from their reset values
   longint      fb_gain = FEEDBACK_GAIN_RST;
   int unsigned tail_len = DELAY_LENGTH_RST;
   longint      damp_k = DAMPING_COEFF_RST;
   longint      tilt_k = $signed(TILT_AMOUNT_RST);
   longint      xover_k = TILT_COEFF_RST;

   logic [SAMPLE_BITS-1:0] pending_samples [$];
   logic [DATA_W-1:0]      expected_out [$];
   int unsigned queued_total = 0;
   int unsigned accepted_total = 0;

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          idling_on = 1'b1;
   int unsigned send_gap = 0;
   int unsigned hold_gap = 0;
   logic [DATA_W-1:0] wanted_out;

   function automatic longint clamp_sample(longint v);
      if (v > SAMPLE_ONE - 1) return SAMPLE_ONE - 1;
      if (v < -SAMPLE_ONE) return -SAMPLE_ONE;
      return v;
   endfunction

   // one sample through the decay tail and the tilt equalizer, updating the state
   function automatic logic [SAMPLE_BITS-1:0] predict_sample(logic [SAMPLE_BITS-1:0] raw);
      longint x, mag, r, sq, c, f, d, hp, lo_gain, hi_gain, mix;
      int unsigned span;
      x = $signed(raw);
      mag = (x < 0) ? -x : x;

      // gate opens fully on a loud sample, otherwise decays
      if (mag > GATE_THRESH) gate_env = SAMPLE_ONE;
      else gate_env = (gate_env * GATE_FALL_Q24) >>> 24;

      // active length: zero acts as one, oversize clamps to the memory
      span = tail_len;
      if (span == 0) span = 1;
      if (span > DELAY_DEPTH) span = DELAY_DEPTH;
      if (tail_ptr >= span) tail_ptr = tail_ptr % span;

      // soft clip r*(3 - r^2)/2, feedback gain, damping lowpass
      r = tail_mem[tail_ptr];
      sq = (r * r) >>> (SAMPLE_BITS - 1);
      c = r + ((r * (SAMPLE_ONE - sq)) >>> SAMPLE_BITS);
      f = (c * fb_gain) >>> 16;
      tail_lp += (damp_k * (f - tail_lp)) >>> 16;

      tail_mem[tail_ptr] = clamp_sample(x + tail_lp);
      tail_ptr = (tail_ptr + 1) % span;

      // tail ducked by up to half while the gate is open
      d = clamp_sample(x + tail_lp - ((tail_lp * gate_env) >>> SAMPLE_BITS));

      // crossover split and opposed band gains
      xover_lp += (xover_k * (d - xover_lp)) >>> 16;
      hp = d - xover_lp;
      if (tilt_k >= 0) begin
         lo_gain = UNITY_Q15 - ((tilt_k * CUT_SCALE) >>> 16);
         hi_gain = UNITY_Q15 + ((tilt_k * 3) >>> 1);
      end else begin
         lo_gain = UNITY_Q15 + ((-tilt_k * 3) >>> 1);
         hi_gain = UNITY_Q15 - ((-tilt_k * CUT_SCALE) >>> 16);
      end
      mix = clamp_sample((xover_lp * lo_gain + hp * hi_gain) >>> 15);
      return mix[SAMPLE_BITS-1:0];
   endfunction

   function automatic void apply_setting(logic [CSR_IDX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_FEEDBACK_GAIN: fb_gain = value[COEF_W-1:0];
         REG_DELAY_LENGTH:  tail_len = value;
         REG_DAMPING_COEFF: damp_k = value[COEF_W-1:0];
         REG_TILT_AMOUNT:   tilt_k = $signed(value[COEF_W-1:0]);
         REG_TILT_COEFF:    xover_k = value[COEF_W-1:0];
         default: ;
      endcase
   endfunction

   // most gaps short, a few long; none while idling is switched off
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (!idling_on || roll < 60) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] draw_sample(signal_mix_t tone);
      longint pick;
      case (tone)
         TONE_FULL:     pick = longint'($urandom);
         TONE_MODERATE: pick = longint'($urandom_range(1 << 21)) - (1 << 20);
         TONE_QUIET:    pick = longint'($urandom_range(2 * GATE_THRESH)) - GATE_THRESH;
         TONE_SILENT:   pick = ($urandom_range(7) == 0) ? longint'($urandom_range(64)) - 32 : 0;
         default: begin
            case ($urandom_range(5))
               0: pick = -SAMPLE_ONE;
               1: pick = SAMPLE_ONE - 1;
               2: pick = GATE_THRESH;
               3: pick = GATE_THRESH + 1;
               4: pick = -GATE_THRESH;
               default: pick = -GATE_THRESH - 1;
            endcase
         end
      endcase
      return pick[SAMPLE_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] wanted);
      if (mismatch_count < REPORT_CAP)
         $display("%0t ns: %s: sample_out got %0d wanted %0d", $time, what,
                  $signed(got[SAMPLE_BITS-1:0]), $signed(wanted[SAMPLE_BITS-1:0]));
      mismatch_count++;
   endtask

   // one register write, model updated at the same time; block is idle here
   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      apply_setting(idx, value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_sample(input logic [SAMPLE_BITS-1:0] s);
      pending_samples.push_back(s);
      queued_total++;
   endtask

   // every queued request accepted and every response checked
   task automatic wait_drained();
      do @(posedge clock);
      while (accepted_total != queued_total || expected_out.size() != 0);
   endtask

   // random coefficient, sometimes zero or all ones, with the unused upper write bits scrambled
   function automatic logic [CSR_DATA_W-1:0] pick_coeff();
      logic [CSR_DATA_W-1:0] v;
      v = $urandom;
      case ($urandom_range(5))
         0: v[COEF_W-1:0] = '0;
         1: v[COEF_W-1:0] = '1;
         default: ;
      endcase
      return v;
   endfunction

   task automatic shuffle_settings();
      int unsigned roll;
      logic [CSR_DATA_W-1:0] len, tilt;
      roll = $urandom_range(99);
      // mostly short loops so the tail recirculates many times
      if (roll < 50) len = $urandom_range(32, 1);
      else if (roll < 78) len = $urandom_range(512, 33);
      else if (roll < 88) len = $urandom_range(4096, 513);
      else if (roll < 94) len = '0;
      else len = $urandom_range((1 << CFG_LEN_W) - 1, DELAY_DEPTH);
      tilt = $urandom;
      case ($urandom_range(5))
         0: tilt[COEF_W-1:0] = 16'h8000;
         1: tilt[COEF_W-1:0] = 16'h7fff;
         2: tilt[COEF_W-1:0] = '0;
         default: ;
      endcase
      if ($urandom_range(3) != 0) write_setting(REG_FEEDBACK_GAIN, pick_coeff());
      if ($urandom_range(3) != 0) write_setting(REG_DELAY_LENGTH, len);
      if ($urandom_range(3) != 0) write_setting(REG_DAMPING_COEFF, pick_coeff());
      if ($urandom_range(3) != 0) write_setting(REG_TILT_AMOUNT, tilt);
      if ($urandom_range(3) != 0) write_setting(REG_TILT_COEFF, pick_coeff());
      if ($urandom_range(4) == 0)
         write_setting(CSR_IDX_W'(REG_SPARE_FIRST + $urandom_range(2)), $urandom);
   endtask

   // request driver: presents queued samples, predicts each one on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_out.push_back(DATA_W'(predict_sample(req_tdata[SAMPLE_BITS-1:0])));
            accepted_total++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_tdata <= DATA_W'(pending_samples.pop_front());
               req_tvalid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_out.size() == 0) begin
               report_mismatch("response with no request waiting", rsp_tdata, '0);
            end else begin
               wanted_out = expected_out.pop_front();
               if (rsp_tdata !== wanted_out)
                  report_mismatch("wrong sample", rsp_tdata, wanted_out);
            end
         end
         if (hold_gap != 0) begin
            hold_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idling_on && $urandom_range(9) == 0) hold_gap = pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      foreach (tail_mem[i]) tail_mem[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // registers at their upper extremes, short loop; written while the memory clears
      write_setting(REG_FEEDBACK_GAIN, 18'h0ffff);
      write_setting(REG_DELAY_LENGTH, 18'd8);
      write_setting(REG_DAMPING_COEFF, 18'h0ffff);
      write_setting(REG_TILT_AMOUNT, 18'h07fff);
      write_setting(REG_TILT_COEFF, 18'h0ffff);
      // writes to unmapped indexes change nothing
      write_setting(REG_SPARE_FIRST, '1);
      write_setting(REG_SPARE_LAST, 18'h15555);
      // full scale both ways, zero, unit steps and both sides of the gate threshold
      queue_sample(draw_sample(TONE_SILENT) & '0 | SAMPLE_BITS'(SAMPLE_ONE - 1));
      queue_sample(SAMPLE_BITS'(-SAMPLE_ONE));
      queue_sample(SAMPLE_BITS'(SAMPLE_ONE - 1));
      queue_sample('0);
      queue_sample(SAMPLE_BITS'(1));
      queue_sample(SAMPLE_BITS'(-1));
      queue_sample(SAMPLE_BITS'(GATE_THRESH));
      queue_sample(SAMPLE_BITS'(GATE_THRESH + 1));
      queue_sample(SAMPLE_BITS'(-GATE_THRESH));
      queue_sample(SAMPLE_BITS'(-GATE_THRESH - 1));
      wait_drained();

      // lower extremes; a zero length behaves as a one-sample loop
      write_setting(REG_DELAY_LENGTH, '0);
      write_setting(REG_FEEDBACK_GAIN, '0);
      write_setting(REG_DAMPING_COEFF, '0);
      write_setting(REG_TILT_AMOUNT, 18'h08000);
      write_setting(REG_TILT_COEFF, '0);
      queue_sample(SAMPLE_BITS'(SAMPLE_ONE - 1));
      queue_sample(SAMPLE_BITS'(-SAMPLE_ONE));
      queue_sample(SAMPLE_BITS'(GATE_THRESH + 1));
      queue_sample('0);
      wait_drained();

      // length above the memory depth clamps to it
      write_setting(REG_DELAY_LENGTH, '1);
      write_setting(REG_FEEDBACK_GAIN, 18'd49152);
      write_setting(REG_DAMPING_COEFF, DAMPING_COEFF_RST);
      write_setting(REG_TILT_AMOUNT, 18'd16384);
      write_setting(REG_TILT_COEFF, TILT_COEFF_RST);
      repeat (7) queue_sample(draw_sample(TONE_EDGE));
      wait_drained();

      // shrinking the loop below the write position wraps the position first
      write_setting(REG_DELAY_LENGTH, 18'd5);
      write_setting(REG_TILT_AMOUNT, TILT_AMOUNT_RST);
      repeat (4) queue_sample(draw_sample(TONE_FULL));
      wait_drained();

      // random phases: new settings, then runs of samples of one character each
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         int unsigned left, chunk;
         shuffle_settings();
         idling_on = ($urandom_range(3) != 0);
         left = PHASE_ITEMS;
         while (left > 0) begin
            signal_mix_t tone;
            chunk = $urandom_range(60, 8);
            if (chunk > left) chunk = left;
            tone = signal_mix_t'($urandom_range(4));
            repeat (chunk) queue_sample(draw_sample(tone));
            left -= chunk;
         end
         wait_drained();
      end

      // catch any stray response after the last one
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== decay_tail_tilt_chain.f =====
+incdir+rtl/core
rtl/core/dtt_pkg.sv
rtl/core/dtt_delay_ram.sv
rtl/core/decay_tail_tilt_chain.sv
test/decay_tail_tilt_chain_test.sv
